// ===== hw/rtl/gha_pkg.sv =====
// ============================================================================
// gha_pkg
// Shared types and constants for the generational handle allocator.
// ============================================================================
`default_nettype none

package gha_pkg;

    // Table geometry
    localparam int SLOT_COUNT = 1024;
    localparam int IDX_BITS   = $clog2(SLOT_COUNT);
    localparam int CNT_BITS   = IDX_BITS + 1;
    localparam int GEN_BITS   = 16;

    // Command codes
    localparam logic [1:0] CMD_ALLOC = 2'd0;
    localparam logic [1:0] CMD_FREE  = 2'd1;
    localparam logic [1:0] CMD_CHECK = 2'd2;

    // Status codes
    localparam logic [1:0] STS_OK    = 2'd0;
    localparam logic [1:0] STS_FULL  = 2'd1;
    localparam logic [1:0] STS_STALE = 2'd2;

    // Request payload
    typedef struct packed {
        logic [1:0]          cmd;
        logic [IDX_BITS-1:0] slot_index;
        logic [GEN_BITS-1:0] slot_generation;
    } req_t;

    // Response payload
    typedef struct packed {
        logic [1:0]          status;
        logic [IDX_BITS-1:0] out_index;
        logic [GEN_BITS-1:0] out_generation;
    } rsp_t;

endpackage

`default_nettype wire

// ===== hw/rtl/gha_ram.sv =====
// ============================================================================
// gha_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// Read data holds its value while no read is issued.
// ============================================================================
`default_nettype none

module gha_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/generational_handle_allocator.sv =====
// ============================================================================
// generational_handle_allocator
// Hands out handles made of a slot index and a generation. Allocate reuses
// the oldest freed slot, else takes a fresh one; free bumps the generation of
// a live handle and queues its slot; check tests a handle for liveness.
// ============================================================================
//
//  Channel  Dir  Payload  Transfer when
//  req      in   req_t    req_valid && !req_stall
//  rsp      out  rsp_t    rsp_valid && !rsp_stall
//
//  One command at a time. A fresh or failed allocate, an unknown command or
//  an index not below the high-water mark needs no RAM read; free, check and
//  a queued allocate read the generation RAM, the last after the queue RAM.
//  Reset clears the high-water mark and the queue pointers; RAM contents are
//  only read after they are written. A new request is taken while a result
//  still waits in the output register; a stalled result holds the last step.
//
`default_nettype none

module generational_handle_allocator (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output      logic          req_stall,
    input  wire gha_pkg::req_t req,
    output      logic          rsp_valid,
    input  wire logic          rsp_stall,
    output      gha_pkg::rsp_t rsp
);

    import gha_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_POP  = 4'b0010,
        ST_LOOK = 4'b0100,
        ST_RESP = 4'b1000
    } state_t;

    state_t              state_reg, state_next;
    logic [1:0]          cmd_reg, cmd_next;
    logic [IDX_BITS-1:0] idx_reg, idx_next;
    logic [GEN_BITS-1:0] gen_reg, gen_next;
    logic [CNT_BITS-1:0] hw_reg, hw_next;
    logic [IDX_BITS-1:0] head_reg, head_next;
    logic [IDX_BITS-1:0] tail_reg, tail_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    rsp_t                res_reg, res_next;
    rsp_t                rsp_reg, rsp_next;
    logic                rsp_valid_reg, rsp_valid_next;

    // Memory ports
    logic                gen_we, gen_re;
    logic [IDX_BITS-1:0] gen_waddr, gen_raddr;
    logic [GEN_BITS-1:0] gen_wdata, gen_rdata;
    logic                q_we, q_re;
    logic [IDX_BITS-1:0] q_waddr, q_raddr;
    logic [IDX_BITS-1:0] q_wdata, q_rdata;

    logic req_xfer;
    logic out_free;

    gha_ram #(
        .WIDTH (GEN_BITS),
        .DEPTH (SLOT_COUNT)
    ) u_gen_ram (
        .clk   (clk),
        .we    (gen_we),
        .waddr (gen_waddr),
        .wdata (gen_wdata),
        .re    (gen_re),
        .raddr (gen_raddr),
        .rdata (gen_rdata)
    );

    gha_ram #(
        .WIDTH (IDX_BITS),
        .DEPTH (SLOT_COUNT)
    ) u_queue_ram (
        .clk   (clk),
        .we    (q_we),
        .waddr (q_waddr),
        .wdata (q_wdata),
        .re    (q_re),
        .raddr (q_raddr),
        .rdata (q_rdata)
    );

    assign req_stall = (state_reg != ST_IDLE);
    assign req_xfer  = req_valid && !req_stall;
    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Command sequencer
    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        idx_next       = idx_reg;
        gen_next       = gen_reg;
        hw_next        = hw_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        cnt_next       = cnt_reg;
        res_next       = res_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;

        gen_we    = 1'b0;
        gen_re    = 1'b0;
        gen_waddr = idx_reg;
        gen_wdata = '0;
        gen_raddr = req.slot_index;
        q_we      = 1'b0;
        q_re      = 1'b0;
        q_waddr   = tail_reg;
        q_wdata   = idx_reg;
        q_raddr   = head_reg;

        // Output register drains independently
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_xfer)
                begin
                    cmd_next = req.cmd;
                    idx_next = req.slot_index;
                    gen_next = req.slot_generation;
                    // Default: stale echo of the handle
                    res_next = '{status: STS_STALE, out_index: req.slot_index,
                                 out_generation: req.slot_generation};
                    state_next = ST_RESP;
                    case (req.cmd)
                        CMD_ALLOC:
                        begin
                            if (cnt_reg != '0)
                            begin
                                q_re       = 1'b1;
                                state_next = ST_POP;
                            end
                            else if (hw_reg < CNT_BITS'(SLOT_COUNT))
                            begin
                                // Fresh slot starts at generation zero
                                gen_we    = 1'b1;
                                gen_waddr = hw_reg[IDX_BITS-1:0];
                                gen_wdata = '0;
                                hw_next   = hw_reg + CNT_BITS'(1);
                                res_next  = '{status: STS_OK,
                                              out_index: hw_reg[IDX_BITS-1:0],
                                              out_generation: '0};
                            end
                            else
                            begin
                                res_next = '{status: STS_FULL, out_index: '0,
                                             out_generation: '0};
                            end
                        end
                        CMD_FREE, CMD_CHECK:
                        begin
                            if ({1'b0, req.slot_index} < hw_reg)
                            begin
                                gen_re     = 1'b1;
                                state_next = ST_LOOK;
                            end
                        end
                        default:
                        begin
                            state_next = ST_RESP;
                        end
                    endcase
                end
            end

            ST_POP:
            begin
                // Queue head arrives; fetch its generation
                gen_re     = 1'b1;
                gen_raddr  = q_rdata;
                idx_next   = q_rdata;
                head_next  = (head_reg == IDX_BITS'(SLOT_COUNT - 1)) ?
                             '0 : head_reg + IDX_BITS'(1);
                cnt_next   = cnt_reg - CNT_BITS'(1);
                state_next = ST_LOOK;
            end

            ST_LOOK:
            begin
                state_next = ST_RESP;
                if (cmd_reg == CMD_ALLOC)
                begin
                    res_next = '{status: STS_OK, out_index: idx_reg,
                                 out_generation: gen_rdata};
                end
                else if (gen_rdata == gen_reg)
                begin
                    res_next = '{status: STS_OK, out_index: idx_reg,
                                 out_generation: gen_reg};
                    if (cmd_reg == CMD_FREE)
                    begin
                        gen_we    = 1'b1;
                        gen_waddr = idx_reg;
                        gen_wdata = gen_rdata + GEN_BITS'(1);
                        // Push is dropped when the queue is full
                        if (cnt_reg != CNT_BITS'(SLOT_COUNT))
                        begin
                            q_we      = 1'b1;
                            q_waddr   = tail_reg;
                            q_wdata   = idx_reg;
                            tail_next = (tail_reg == IDX_BITS'(SLOT_COUNT - 1)) ?
                                        '0 : tail_reg + IDX_BITS'(1);
                            cnt_next  = cnt_reg + CNT_BITS'(1);
                        end
                    end
                end
                else
                begin
                    res_next = '{status: STS_STALE, out_index: idx_reg,
                                 out_generation: gen_reg};
                end
            end

            ST_RESP:
            begin
                if (out_free)
                begin
                    rsp_next       = res_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            hw_reg        <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            hw_reg        <= hw_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            cnt_reg       <= cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        idx_reg <= idx_next;
        gen_reg <= gen_next;
        res_reg <= res_next;
        rsp_reg <= rsp_next;
    end

    // Checks
    a_cnt_range : assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_BITS'(SLOT_COUNT))
        else $error("free queue count out of range");

    a_hw_range : assert property (@(posedge clk) disable iff (!rst_n)
        hw_reg <= CNT_BITS'(SLOT_COUNT))
        else $error("high-water mark out of range");

    a_rsp_from_resp : assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == ST_RESP))
        else $error("response loaded outside the response step");

    a_pop_only : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_POP) |=> (cnt_reg == $past(cnt_reg) - CNT_BITS'(1)))
        else $error("queue pop did not decrement the count");

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// ============================================================================
// testbench
// Self-checking bench for the generational handle allocator. Requests are
// driven on the req channel and results are checked on the rsp channel
// against an in-bench model of the slot table, the high-water mark and the
// reuse queue. A table of directed requests comes first. Random traffic
// follows, mostly live handles drawn from the model's own state. Then a
// phase fills the table past full, and a run of frees on one slot queues
// that slot many times over before mixed traffic reuses it.
// ============================================================================

module testbench;

    import gha_pkg::*;

    localparam logic [1:0] CMD_UNUSED  = 2'd3;
    localparam int         CYCLE_LIMIT = 200_000;
    localparam int         GEN_SPAN    = 1 << GEN_BITS;
    localparam int         WANT_DEPTH  = 16;

    // One directed request, with its result typed in where it is obvious
    typedef struct packed {
        req_t item;
        bit   typed;
        rsp_t want;
    } stim_row_t;

    localparam int DIRECTED_ROWS = 21;
    localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
        // empty table: nothing is live, unknown command echoes
        '{'{CMD_CHECK,  10'd0,    16'd0},      1'b1, '{STS_STALE, 10'd0,    16'd0}},
        '{'{CMD_FREE,   10'd0,    16'd0},      1'b1, '{STS_STALE, 10'd0,    16'd0}},
        '{'{CMD_UNUSED, 10'd1023, 16'hFFFF},   1'b1, '{STS_STALE, 10'd1023, 16'hFFFF}},
        // fresh slots come out with generation zero
        '{'{CMD_ALLOC,  10'd0,    16'd0},      1'b1, '{STS_OK,    10'd0,    16'd0}},
        '{'{CMD_ALLOC,  10'd0,    16'd0},      1'b1, '{STS_OK,    10'd1,    16'd0}},
        '{'{CMD_CHECK,  10'd0,    16'd0},      1'b1, '{STS_OK,    10'd0,    16'd0}},
        '{'{CMD_CHECK,  10'd0,    16'hFFFF},   1'b1, '{STS_STALE, 10'd0,    16'hFFFF}},
        // index at or above the high-water mark
        '{'{CMD_CHECK,  10'd1023, 16'd0},      1'b1, '{STS_STALE, 10'd1023, 16'd0}},
        '{'{CMD_CHECK,  10'd2,    16'd0},      1'b1, '{STS_STALE, 10'd2,    16'd0}},
        // free, then the same handle again is stale
        '{'{CMD_FREE,   10'd1,    16'd0},      1'b1, '{STS_OK,    10'd1,    16'd0}},
        '{'{CMD_FREE,   10'd1,    16'd0},      1'b1, '{STS_STALE, 10'd1,    16'd0}},
        '{'{CMD_CHECK,  10'd1,    16'd1},      1'b0, '0},
        // second free of a queued slot queues it twice
        '{'{CMD_FREE,   10'd1,    16'd1},      1'b0, '0},
        '{'{CMD_ALLOC,  10'd0,    16'd0},      1'b0, '0},
        '{'{CMD_ALLOC,  10'd0,    16'd0},      1'b0, '0},
        '{'{CMD_ALLOC,  10'd0,    16'd0},      1'b0, '0},
        '{'{CMD_FREE,   10'd0,    16'hFFFF},   1'b0, '0},
        '{'{CMD_UNUSED, 10'd0,    16'd0},      1'b1, '{STS_STALE, 10'd0,    16'd0}},
        '{'{CMD_CHECK,  10'd1,    16'd2},      1'b0, '0},
        '{'{CMD_FREE,   10'd2,    16'd0},      1'b0, '0},
        '{'{CMD_ALLOC,  10'd0,    16'd0},      1'b0, '0}
    };

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req       = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    // Model state: slot generations, high-water mark, reuse queue
    bit   [GEN_BITS-1:0] slot_gen    [SLOT_COUNT];
    bit   [IDX_BITS-1:0] reuse_queue [SLOT_COUNT];
    int                  high_water  = 0;
    int                  reuse_head  = 0;
    int                  reuse_tail  = 0;
    int                  reuse_count = 0;

    // Expected results in transfer order
    rsp_t        want_ring [WANT_DEPTH];
    int          want_wr_count     = 0;
    int          want_rd_count     = 0;
    int          fail_count        = 0;
    int          sender_idle_pct   = 0;
    int          receiver_idle_pct = 0;
    int unsigned cycle_count       = 0;

    generational_handle_allocator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // Run the allocator model on one accepted request
    task automatic predict_handle(input req_t item, output rsp_t result);
        logic [IDX_BITS-1:0] slot;
        bit                  live;
        live   = (int'(item.slot_index) < high_water)
                 && (slot_gen[item.slot_index] == item.slot_generation);
        result = '{STS_STALE, item.slot_index, item.slot_generation};
        case (item.cmd)
            CMD_ALLOC:
            begin
                if (reuse_count > 0)
                begin
                    slot        = reuse_queue[reuse_head];
                    reuse_head  = (reuse_head + 1) % SLOT_COUNT;
                    reuse_count = reuse_count - 1;
                    result      = '{STS_OK, slot, slot_gen[slot]};
                end
                else if (high_water < SLOT_COUNT)
                begin
                    slot           = IDX_BITS'(high_water);
                    slot_gen[slot] = '0;
                    high_water     = high_water + 1;
                    result         = '{STS_OK, slot, slot_gen[slot]};
                end
                else
                begin
                    result = '{STS_FULL, '0, '0};
                end
            end
            CMD_FREE:
            begin
                if (live)
                begin
                    slot_gen[item.slot_index] = slot_gen[item.slot_index] + 1'b1;
                    // queue saturates: the push is dropped when full
                    if (reuse_count < SLOT_COUNT)
                    begin
                        reuse_queue[reuse_tail] = item.slot_index;
                        reuse_tail              = (reuse_tail + 1) % SLOT_COUNT;
                        reuse_count             = reuse_count + 1;
                    end
                    result.status = STS_OK;
                end
            end
            CMD_CHECK:
            begin
                if (live)
                    result.status = STS_OK;
            end
            default:
            begin
            end
        endcase
    endtask

    // Random command, mostly on handles the model knows to be live
    task automatic pick_handle_command(output req_t item);
        int pick;
        int idx;
        pick                 = $urandom_range(0, 99);
        item.cmd             = CMD_CHECK;
        item.slot_index      = IDX_BITS'($urandom_range(0, SLOT_COUNT - 1));
        item.slot_generation = GEN_BITS'($urandom_range(0, GEN_SPAN - 1));
        if (pick < 30)
        begin
            item.cmd = CMD_ALLOC;
        end
        else if (pick < 88 && high_water > 0)
        begin
            idx                  = $urandom_range(0, high_water - 1);
            item.slot_index      = IDX_BITS'(idx);
            item.slot_generation = slot_gen[idx];
            if (pick < 60)
                item.cmd = CMD_FREE;
            else if (pick < 80)
                item.cmd = CMD_CHECK;
            else
            begin
                // stale free: any generation but the stored one
                item.cmd             = CMD_FREE;
                item.slot_generation = slot_gen[idx]
                                       + GEN_BITS'($urandom_range(1, GEN_SPAN - 1));
            end
        end
        else if (pick >= 95)
        begin
            item.cmd = CMD_UNUSED;
        end
    endtask

    // Drive one request until its transfer, then record the expected result
    task automatic send_item(input req_t item, input bit use_typed, input rsp_t typed_rsp);
        rsp_t predicted;
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        predict_handle(item, predicted);
        want_ring[want_wr_count % WANT_DEPTH] = use_typed ? typed_rsp : predicted;
        want_wr_count = want_wr_count + 1;
    endtask

    task automatic note_failure(input string msg);
        fail_count = fail_count + 1;
        if (fail_count <= 10)
            $display("%s", msg);
    endtask

    // Result checker and receiver back-pressure
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n)
        begin
            if (rsp_valid === 1'b1 && rsp_stall === 1'b0)
            begin
                if (want_wr_count == want_rd_count)
                begin
                    note_failure($sformatf("unexpected result: status %0d index %0d gen %0d",
                                           rsp.status, rsp.out_index, rsp.out_generation));
                end
                else
                begin
                    want          = want_ring[want_rd_count % WANT_DEPTH];
                    want_rd_count = want_rd_count + 1;
                    if (rsp.status !== want.status || rsp.out_index !== want.out_index
                        || rsp.out_generation !== want.out_generation)
                    begin
                        note_failure($sformatf(
                            "result mismatch: status %0d/%0d index %0d/%0d gen %0d/%0d (exp/act)",
                            want.status, rsp.status, want.out_index, rsp.out_index,
                            want.out_generation, rsp.out_generation));
                    end
                end
            end
            rsp_stall <= ($urandom_range(0, 99) < receiver_idle_pct);
        end
    end

    // Watchdog
    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("generational_handle_allocator verification failed");
        $finish;
    end

    initial
    begin
        req_t item;
        int   fill_allocs;
        int   hammer_slot;

        sender_idle_pct   = 9;
        receiver_idle_pct = 70;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed table
        foreach (DIRECTED[i])
            send_item(DIRECTED[i].item, DIRECTED[i].typed, DIRECTED[i].want);

        // random traffic under the three back-pressure mixes
        repeat (100)
        begin
            pick_handle_command(item);
            send_item(item, 1'b0, '0);
        end
        sender_idle_pct   = 70;
        receiver_idle_pct = 9;
        repeat (100)
        begin
            pick_handle_command(item);
            send_item(item, 1'b0, '0);
        end
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        repeat (100)
        begin
            pick_handle_command(item);
            send_item(item, 1'b0, '0);
        end

        // drain the reuse queue, use every slot, then hit the full table
        fill_allocs = reuse_count + (SLOT_COUNT - high_water) + 4;
        repeat (fill_allocs)
        begin
            item = '{CMD_ALLOC, IDX_BITS'($urandom_range(0, SLOT_COUNT - 1)),
                     GEN_BITS'($urandom_range(0, GEN_SPAN - 1))};
            send_item(item, 1'b0, '0);
        end

        // free one slot over and over: the queue holds it many times
        hammer_slot = $urandom_range(0, SLOT_COUNT - 1);
        repeat (40)
        begin
            item = '{CMD_FREE, IDX_BITS'(hammer_slot), slot_gen[hammer_slot]};
            send_item(item, 1'b0, '0);
        end

        // allocations from the repeated entries plus mixed traffic
        repeat (60)
        begin
            pick_handle_command(item);
            send_item(item, 1'b0, '0);
        end
        req_valid <= 1'b0;

        while (want_wr_count != want_rd_count)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (fail_count == 0)
            $display("generational_handle_allocator verification clean");
        else
            $display("generational_handle_allocator verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/gha_pkg.sv
hw/rtl/gha_ram.sv
hw/rtl/generational_handle_allocator.sv
dv/testbench.sv
